// File: src/tga_rle_pkg.sv
// Shared types and constants of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

package tga_rle_pkg;

  localparam int unsigned MAX_PIXEL_BYTES = 4;
  localparam int unsigned PIX_W           = 32;
  localparam int unsigned IDX_W           = 32;
  localparam int unsigned CNT_W           = 8;
  localparam int unsigned BPP_W           = 3;
  localparam int unsigned DIM_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [BPP_W-1:0] BPP_RESET    = 3'd3;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd1;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd1;

  // Header bytes at or above this value open a run packet.
  localparam logic [7:0] RUN_FLAG = 8'd128;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLIP  = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic [BPP_W-1:0] pix_size;
    logic [IDX_W-1:0] total;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel_value;
    logic [IDX_W-1:0] start_index;
    logic [CNT_W-1:0] repeat_count;
    status_e          status;
    logic             image_done;
  } res_t;

endpackage

// File: src/tga_in_if.sv
// Input byte stream channel of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: src/tga_out_if.sv
// Result channel of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

interface tga_out_if
  import tga_rle_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic [IDX_W-1:0] start_index;
  logic [CNT_W-1:0] repeat_count;
  status_e          status;
  logic             image_done;

  modport source (output valid, output pixel_value, output start_index,
                  output repeat_count, output status, output image_done, input ready);
  modport sink   (input valid, input pixel_value, input start_index,
                  input repeat_count, input status, input image_done, output ready);
endinterface

// File: src/tga_rle_pixel_decoder_core.sv
// Top level of the TGA run-length pixel decoder.
`timescale 1ns / 1ps
// The block takes the image data of a run-length coded TGA file one byte per
// request on in_i and returns decoded pixels on out_o, each with its linear
// start index and repeat count: one result per raw pixel, one per run packet.
// Configuration (pixel size, width, height) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write it only while the block is
// idle; the block does not enforce it. A write takes effect at the next edge,
// together with the registered pixel total of the image. A result shows on
// out_o in the cycle after the byte that completes it is accepted. Throughput:
// one byte per cycle, set by the single decode step between the state
// registers and the result register. The result register lets a new byte in
// while a result waits, as long as that result leaves in the same cycle; when
// the receiver stalls, in_i.ready drops and the decode state holds.
// Reset returns the registers to 3 bytes per pixel and a 1 by 1 image, and
// the decoder waits for a packet header. Once the image is complete or the
// stream was truncated, further bytes are accepted and ignored until reset.

module tga_rle_pixel_decoder_core
  import tga_rle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tga_in_if.sink                in_i,
  tga_out_if.source             out_o
);

  cfg_t cfg;
  res_t step_res;
  res_t out_res;
  logic in_ready;
  logic acc;
  logic finished;

  assign acc        = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  tga_rle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tga_rle_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .cfg_i        (cfg),
    .res_o        (step_res),
    .finished_o   (finished)
  );

  tga_rle_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (step_res),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .res_o       (out_res)
  );

  assign out_o.valid        = out_res.valid;
  assign out_o.pixel_value  = out_res.pixel_value;
  assign out_o.start_index  = out_res.start_index;
  assign out_o.repeat_count = out_res.repeat_count;
  assign out_o.status       = out_res.status;
  assign out_o.image_done   = out_res.image_done;

  // No result is produced once the decoder has finished.
  a_no_res_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished |-> !step_res.valid)
    else $error("result produced after decoding finished");

  // A result from an accepted byte is on the channel in the next cycle.
  a_res_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_res.valid |=> out_o.valid)
    else $error("decoded result did not reach the output register");

  // A truncated stream never reports a completed image.
  a_trunc_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_TRUNC) |-> !out_o.image_done)
    else $error("truncated result flagged as image done");

  // Pixel results always cover at least one pixel.
  a_pixel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_TRUNC) |-> (out_o.repeat_count != '0))
    else $error("pixel result with zero repeat count");

endmodule

// File: src/tga_rle_cfg.sv
// Configuration registers and the registered pixel total of the image.
`timescale 1ns / 1ps

module tga_rle_cfg
  import tga_rle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [BPP_W-1:0] bpp_q, bpp_d;
  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  logic [IDX_W-1:0] total_q, total_d;
  logic [DIM_W-1:0] mul_a, mul_b;

  always_comb begin
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BPP:    bpp_d    = cfg_wdata_i[BPP_W-1:0];
        CFG_WIDTH:  width_d  = cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_d = cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
    // The product follows the new dimensions at the same edge as the write.
    mul_a   = width_d;
    mul_b   = height_d;
    total_d = IDX_W'(mul_a * mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BPP_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      total_q  <= IDX_W'(WIDTH_RESET * HEIGHT_RESET);
    end else if (cfg_we_i) begin
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= total_d;
    end
  end

  always_comb begin
    cfg_o.total = total_q;
    if (bpp_q == '0) begin
      cfg_o.pix_size = BPP_W'(1);
    end else if (bpp_q > BPP_W'(MAX_PIXEL_BYTES)) begin
      cfg_o.pix_size = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      cfg_o.pix_size = bpp_q;
    end
  end

endmodule

// File: src/tga_rle_step.sv
// Packet decoding state and the per-byte decode logic.
`timescale 1ns / 1ps

module tga_rle_step
  import tga_rle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o,
  output logic       finished_o
);

  logic             expect_hdr_q, expect_hdr_d;
  logic             is_run_q, is_run_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic [1:0]       bip_q, bip_d;
  logic [PIX_W-1:0] asm_q, asm_d;
  logic [IDX_W-1:0] next_q, next_d;
  logic             finished_q, finished_d;

  logic [IDX_W:0]   rem_w;
  logic [IDX_W-1:0] rem;
  logic             no_room, rem_narrow;
  logic             run_clip, run_done;
  logic [PIX_W-1:0] asm_new;
  logic [1:0]       bip_new;
  logic [CNT_W-1:0] raw_left;
  logic             done;
  status_e          st;

  always_comb begin
    rem_w      = {1'b0, cfg_i.total} - {1'b0, next_q};
    rem        = rem_w[IDX_W-1:0];
    no_room    = rem_w[IDX_W] || (rem == '0);
    rem_narrow = (rem[IDX_W-1:CNT_W] == '0);
    run_clip   = rem_narrow && (left_q > rem[CNT_W-1:0]);
    run_done   = rem_narrow && (left_q >= rem[CNT_W-1:0]);
    raw_left   = (left_q != '0) ? left_q - CNT_W'(1) : '0;
    bip_new    = bip_q + 2'd1;
    asm_new    = asm_q;
    case (bip_q)
      2'd0:    asm_new[7:0]   = asm_q[7:0]   | data_byte_i;
      2'd1:    asm_new[15:8]  = asm_q[15:8]  | data_byte_i;
      2'd2:    asm_new[23:16] = asm_q[23:16] | data_byte_i;
      default: asm_new[31:24] = asm_q[31:24] | data_byte_i;
    endcase

    expect_hdr_d = expect_hdr_q;
    is_run_d     = is_run_q;
    left_d       = left_q;
    bip_d        = bip_q;
    asm_d        = asm_q;
    next_d       = next_q;
    finished_d   = finished_q;
    done         = 1'b0;
    st           = ST_OK;

    res_o              = '0;
    res_o.status       = ST_TRUNC;
    res_o.start_index  = next_q;

    if (acc_i && !finished_q) begin
      if (no_room) begin
        finished_d = 1'b1;
      end else if (expect_hdr_q) begin
        is_run_d     = (data_byte_i >= RUN_FLAG);
        left_d       = (data_byte_i >= RUN_FLAG) ? data_byte_i - RUN_BIAS
                                                 : data_byte_i + 8'd1;
        expect_hdr_d = 1'b0;
        bip_d        = '0;
        asm_d        = '0;
        if (final_byte_i) begin
          finished_d  = 1'b1;
          res_o.valid = 1'b1;
        end
      end else if (bip_new != 2'd0 && {1'b0, bip_new} < cfg_i.pix_size) begin
        asm_d = asm_new;
        bip_d = bip_new;
        if (final_byte_i) begin
          finished_d  = 1'b1;
          res_o.valid = 1'b1;
        end
      end else begin
        // A pixel is complete.
        bip_d = '0;
        asm_d = '0;
        res_o.pixel_value = asm_new;
        if (is_run_q) begin
          left_d       = '0;
          expect_hdr_d = 1'b1;
          done         = run_done;
          if (run_clip) begin
            st                 = ST_CLIP;
            res_o.repeat_count = rem[CNT_W-1:0];
            next_d             = cfg_i.total;
          end else begin
            res_o.repeat_count = left_q;
            next_d             = next_q + IDX_W'(left_q);
          end
        end else begin
          left_d             = raw_left;
          expect_hdr_d       = (raw_left == '0);
          done               = (rem == IDX_W'(1));
          st                 = (done && raw_left != '0) ? ST_CLIP : ST_OK;
          res_o.repeat_count = CNT_W'(1);
          next_d             = next_q + IDX_W'(1);
        end
        if (done) begin
          finished_d = 1'b1;
        end else if (final_byte_i) begin
          finished_d = 1'b1;
          st         = ST_TRUNC;
        end
        res_o.valid      = 1'b1;
        res_o.status     = st;
        res_o.image_done = done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
      is_run_q     <= 1'b0;
      left_q       <= '0;
      bip_q        <= '0;
      asm_q        <= '0;
      next_q       <= '0;
      finished_q   <= 1'b0;
    end else begin
      expect_hdr_q <= expect_hdr_d;
      is_run_q     <= is_run_d;
      left_q       <= left_d;
      bip_q        <= bip_d;
      asm_q        <= asm_d;
      next_q       <= next_d;
      finished_q   <= finished_d;
    end
  end

  assign finished_o = finished_q;

endmodule

// File: src/tga_rle_outreg.sv
// Result register that parts the decoder from the result channel.
`timescale 1ns / 1ps

module tga_rle_outreg
  import tga_rle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t data_q;

  // A new request may enter whenever the held result leaves in the same cycle.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    res_o       = data_q;
    res_o.valid = valid_q;
  end

endmodule
